// File: rtl/bcds_pkg.sv
// Shared types and constants of the braille cell drive sequencer.
`default_nettype none

package bcds_pkg;

    localparam int DEF_COLUMN_COUNT = 8;
    localparam int DEF_ROW_COUNT    = 4;

    localparam int CHAN_W      = 36;
    localparam int HOLD_W      = 16;
    localparam int ROW_FIELD_W = 3;
    localparam int COL_FIELD_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int MAX_FRAME_PAIRS = 4;
    localparam int PAIR_W          = 2;
    localparam int PHASE_W         = 2;

    localparam logic [HOLD_W-1:0] DRIVE_TIME_RESET = 16'd7000;
    localparam logic [HOLD_W-1:0] REST_TIME_RESET  = 16'd4000;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_TIME  = 1'd1;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_REFRESH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_DOT   = 2'd1,
        KIND_FRAME = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [PHASE_W-1:0] {
        PH_DRIVE_LOW  = 2'd0,
        PH_REST_A     = 2'd1,
        PH_DRIVE_HIGH = 2'd2,
        PH_REST_B     = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RESP,
        ST_FETCH,
        ST_FRAME
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic              fetch;
        logic              resp_load;
        logic              frame_load;
        logic [PAIR_W-1:0] pair;
        t_phase            phase;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_refresh;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/bcds_in_if.sv
// Command channel of the braille cell drive sequencer.
`default_nettype none

interface bcds_in_if;
    logic                                  valid;
    logic                                  ready;
    bcds_pkg::t_cmd                        cmd;
    logic [bcds_pkg::ROW_FIELD_W-1:0]      dot_row;
    logic [bcds_pkg::COL_FIELD_W-1:0]      dot_col;
    logic                                  dot_on;

    modport source (output valid, cmd, dot_row, dot_col, dot_on, input ready);
    modport sink   (input valid, cmd, dot_row, dot_col, dot_on, output ready);
endinterface

`default_nettype wire

// File: rtl/bcds_out_if.sv
// Result channel of the braille cell drive sequencer.
`default_nettype none

interface bcds_out_if;
    logic                             valid;
    logic                             ready;
    bcds_pkg::t_kind                  result_kind;
    logic                             dot_value;
    logic [bcds_pkg::CHAN_W-1:0]      channel_enable;
    logic [bcds_pkg::CHAN_W-1:0]      channel_level;
    logic [bcds_pkg::HOLD_W-1:0]      hold_time_us;
    logic                             last;

    modport source (output valid, result_kind, dot_value, channel_enable, channel_level,
                    hold_time_us, last, input ready);
    modport sink   (input valid, result_kind, dot_value, channel_enable, channel_level,
                    hold_time_us, last, output ready);
endinterface

`default_nettype wire

// File: rtl/bcds_ctrl.sv
// Controller state machine: command sequencing and refresh frame counting.
`default_nettype none

module bcds_ctrl #(
    parameter int FRAME_PAIRS = bcds_pkg::MAX_FRAME_PAIRS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  bcds_pkg::t_dp_stat i_stat,
    output bcds_pkg::t_dp_cmd  o_cmd
);

    localparam logic [bcds_pkg::PAIR_W-1:0] LAST_PAIR = bcds_pkg::PAIR_W'(FRAME_PAIRS - 1);

    bcds_pkg::t_state                r_state, n_state;
    logic [bcds_pkg::PAIR_W-1:0]     r_pair, n_pair;
    bcds_pkg::t_phase                r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcds_pkg::ST_IDLE;
            r_pair  <= '0;
            r_phase <= bcds_pkg::PH_DRIVE_LOW;
        end else begin
            r_state <= n_state;
            r_pair  <= n_pair;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_pair           = r_pair;
        n_phase          = r_phase;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.pair       = r_pair;
        o_cmd.phase      = r_phase;
        o_cmd.last       = (r_phase == bcds_pkg::PH_REST_B) && (r_pair == LAST_PAIR);
        case (r_state)
            bcds_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = bcds_pkg::ST_DECODE;
                end
            end
            bcds_pkg::ST_DECODE: begin
                o_cmd.rd_en = 1'b1;
                n_pair      = '0;
                n_phase     = bcds_pkg::PH_DRIVE_LOW;
                n_state     = i_stat.is_refresh ? bcds_pkg::ST_FETCH : bcds_pkg::ST_RESP;
            end
            bcds_pkg::ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = bcds_pkg::ST_IDLE;
                end
            end
            bcds_pkg::ST_FETCH: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.fetch = 1'b1;
                n_state     = bcds_pkg::ST_FRAME;
            end
            bcds_pkg::ST_FRAME: begin
                if (i_stat.out_free) begin
                    o_cmd.frame_load = 1'b1;
                    n_phase          = bcds_pkg::t_phase'(r_phase + 2'd1);
                    if (r_phase == bcds_pkg::PH_REST_B) begin
                        if (r_pair == LAST_PAIR) begin
                            n_state = bcds_pkg::ST_IDLE;
                        end else begin
                            n_pair  = r_pair + 1'b1;
                            n_state = bcds_pkg::ST_FETCH;
                        end
                    end
                end
            end
            default: begin
                n_state = bcds_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair <= LAST_PAIR)
        else $error("pair counter beyond last pair");
    a_fetch_then_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcds_pkg::ST_FETCH) |=> (r_state == bcds_pkg::ST_FRAME)
            && (r_phase == bcds_pkg::PH_DRIVE_LOW))
        else $error("frame sequence did not start at first phase");
    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == bcds_pkg::ST_IDLE))
        else $error("command taken outside idle");
`endif

endmodule

`default_nettype wire

// File: rtl/bcds_datapath.sv
// Datapath: dot pattern memory, timing registers, frame build and result register.
`default_nettype none

module bcds_datapath #(
    parameter int COLUMN_COUNT = bcds_pkg::DEF_COLUMN_COUNT,
    parameter int ROW_COUNT    = bcds_pkg::DEF_ROW_COUNT
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_capture,
    input  bcds_pkg::t_cmd                     i_in_cmd,
    input  wire [bcds_pkg::ROW_FIELD_W-1:0]    i_in_row,
    input  wire [bcds_pkg::COL_FIELD_W-1:0]    i_in_col,
    input  wire                                i_in_on,
    input  wire                                i_cfg_we,
    input  wire [bcds_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [bcds_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  bcds_pkg::t_dp_cmd                  i_cmd,
    output bcds_pkg::t_dp_stat                 o_stat,
    bcds_out_if.source                         o_res
);

    localparam int COL_IW   = $clog2(COLUMN_COUNT);
    localparam int ROW_IW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int PWORD_W  = 2 * ROW_COUNT;
    localparam int BASE_W   = $clog2(2 * ROW_COUNT * bcds_pkg::MAX_FRAME_PAIRS);
    localparam int CH_IW    = $clog2(COLUMN_COUNT * ROW_COUNT + bcds_pkg::MAX_FRAME_PAIRS);
    localparam int CHAN_W   = bcds_pkg::CHAN_W;
    localparam int HOLD_W   = bcds_pkg::HOLD_W;

    // captured command
    bcds_pkg::t_cmd                     r_cmd;
    logic [bcds_pkg::ROW_FIELD_W-1:0]   r_row;
    logic [bcds_pkg::COL_FIELD_W-1:0]   r_col;
    logic                               r_on;

    logic [HOLD_W-1:0]                  r_drive_time;
    logic [HOLD_W-1:0]                  r_rest_time;

    logic [ROW_COUNT-1:0]               r_mem [COLUMN_COUNT];
    logic [COLUMN_COUNT-1:0]            r_valid;
    logic [ROW_COUNT-1:0]               r_rd_a;
    logic [ROW_COUNT-1:0]               r_rd_b;
    logic                               r_b_ok;

    logic                               r_out_valid;
    bcds_pkg::t_kind                    r_kind;
    logic                               r_dot;
    logic [CHAN_W-1:0]                  r_en;
    logic [CHAN_W-1:0]                  r_lv;
    logic [HOLD_W-1:0]                  r_hold;
    logic                               r_last;

    logic                               row_ok;
    logic                               col_ok;
    logic [COL_IW-1:0]                  col_idx;
    logic [COL_IW-1:0]                  a_idx;
    logic [COL_IW:0]                    b_wide;
    logic [COL_IW-1:0]                  b_idx;
    logic                               b_ok;
    logic                               wr_en;
    logic                               clr_en;
    logic [ROW_COUNT-1:0]               row_mask;
    logic [ROW_COUNT-1:0]               wr_word;
    logic                               load;

    bcds_pkg::t_kind                    n_kind;
    logic                               n_dot;
    logic [CHAN_W-1:0]                  n_en;
    logic [CHAN_W-1:0]                  n_lv;
    logic [HOLD_W-1:0]                  n_hold;
    logic                               n_last;

    logic [PWORD_W-1:0]                 raised;
    logic [PWORD_W-1:0]                 lowered;
    logic [PWORD_W-1:0]                 exists;
    logic [BASE_W-1:0]                  base;
    logic [CH_IW-1:0]                   common_ch;
    logic [CHAN_W-1:0]                  common_bit;
    logic [CHAN_W-1:0]                  raised_ch;
    logic [CHAN_W-1:0]                  lowered_ch;

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_cmd <= i_in_cmd;
            r_row <= i_in_row;
            r_col <= i_in_col;
            r_on  <= i_in_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_time <= bcds_pkg::DRIVE_TIME_RESET;
            r_rest_time  <= bcds_pkg::REST_TIME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcds_pkg::REG_DRIVE_TIME: r_drive_time <= i_cfg_data;
                bcds_pkg::REG_REST_TIME:  r_rest_time  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign row_ok  = 4'(r_row) < 4'(ROW_COUNT);
    assign col_ok  = 5'(r_col) < 5'(COLUMN_COUNT);
    assign col_idx = r_col[COL_IW-1:0];
    assign a_idx   = i_cmd.fetch ? COL_IW'({i_cmd.pair, 1'b0}) : col_idx;
    assign b_wide  = (COL_IW + 1)'({i_cmd.pair, 1'b1});
    assign b_idx   = b_wide[COL_IW-1:0];
    assign b_ok    = b_wide < (COL_IW + 1)'(COLUMN_COUNT);

    assign wr_en    = i_cmd.resp_load && (r_cmd == bcds_pkg::CMD_WRITE) && row_ok && col_ok;
    assign clr_en   = i_cmd.resp_load && (r_cmd == bcds_pkg::CMD_CLEAR);
    assign row_mask = ROW_COUNT'(1) << r_row[ROW_IW-1:0];
    assign wr_word  = r_on ? (r_rd_a | row_mask) : (r_rd_a & ~row_mask);

    // entries not written since reset or clear read as all dots lowered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_en) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[col_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[col_idx] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_a <= r_valid[a_idx] ? r_mem[a_idx] : '0;
            r_rd_b <= (b_ok && r_valid[b_idx]) ? r_mem[b_idx] : '0;
            r_b_ok <= b_ok;
        end
    end

    // frame build for the current column pair
    assign raised     = {r_rd_b, r_rd_a};
    assign exists     = {{ROW_COUNT{r_b_ok}}, {ROW_COUNT{1'b1}}};
    assign lowered    = ~raised & exists;
    assign base       = BASE_W'(i_cmd.pair) * BASE_W'(2 * ROW_COUNT);
    assign common_ch  = CH_IW'(COLUMN_COUNT * ROW_COUNT) + CH_IW'(i_cmd.pair);
    assign common_bit = CHAN_W'(1) << common_ch;
    assign raised_ch  = CHAN_W'(raised) << base;
    assign lowered_ch = CHAN_W'(lowered) << base;

    always_comb begin
        n_kind = bcds_pkg::KIND_ACK;
        n_dot  = 1'b0;
        n_en   = '0;
        n_lv   = '0;
        n_hold = '0;
        n_last = 1'b1;
        if (i_cmd.frame_load) begin
            n_kind = bcds_pkg::KIND_FRAME;
            n_last = i_cmd.last;
            case (i_cmd.phase)
                bcds_pkg::PH_DRIVE_LOW: begin
                    n_en   = common_bit | raised_ch;
                    n_lv   = raised_ch;
                    n_hold = r_drive_time;
                end
                bcds_pkg::PH_DRIVE_HIGH: begin
                    n_en   = common_bit | lowered_ch;
                    n_lv   = common_bit;
                    n_hold = r_drive_time;
                end
                default: begin
                    n_hold = r_rest_time;
                end
            endcase
        end else begin
            case (r_cmd)
                bcds_pkg::CMD_WRITE: begin
                    n_kind = (row_ok && col_ok) ? bcds_pkg::KIND_ACK : bcds_pkg::KIND_ERROR;
                end
                bcds_pkg::CMD_READ: begin
                    if (row_ok && col_ok) begin
                        n_kind = bcds_pkg::KIND_DOT;
                        n_dot  = r_rd_a[r_row[ROW_IW-1:0]];
                    end else begin
                        n_kind = bcds_pkg::KIND_ERROR;
                    end
                end
                default: begin
                    n_kind = bcds_pkg::KIND_ACK;
                end
            endcase
        end
    end

    assign load = i_cmd.resp_load || i_cmd.frame_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_dot  <= n_dot;
            r_en   <= n_en;
            r_lv   <= n_lv;
            r_hold <= n_hold;
            r_last <= n_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_kind;
    assign o_res.dot_value      = r_dot;
    assign o_res.channel_enable = r_en;
    assign o_res.channel_level  = r_lv;
    assign o_res.hold_time_us   = r_hold;
    assign o_res.last           = r_last;

    assign o_stat.is_refresh = (r_cmd == bcds_pkg::CMD_REFRESH);
    assign o_stat.out_free   = !r_out_valid || o_res.ready;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || o_res.ready))
        else $error("result register loaded while a result is pending");
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.resp_load && i_cmd.frame_load))
        else $error("response and frame loaded together");
    a_last_frame_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.frame_load && i_cmd.last) |-> (i_cmd.phase == bcds_pkg::PH_REST_B))
        else $error("last frame not at final phase");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> $past(5'(r_col)) < 5'(COLUMN_COUNT))
        else $error("pattern write outside column range");
`endif

endmodule

`default_nettype wire

// File: rtl/braille_cell_drive_sequencer.sv
// Braille cell drive sequencer: dot pattern store and H-bridge refresh frame sequencer.
//
// Commands arrive one at a time on i_cmd and each gives one or more transfers on o_res,
// the final one marked by last. A command is taken only when the previous one has
// finished its work; its results leave through a single output register, so the next
// command may be taken while the last result still waits. Clear, write and read go
// from transfer to result register through capture, a registered pattern read and the
// response, which waits while the output is stalled. Refresh decodes, then for each
// column pair reads both columns through the pattern memory's registered read ports
// and gives its four frames, each waiting while the output is stalled. Hold times come
// from the two timing registers, written through i_cfg_we/i_cfg_idx/i_cfg_data. Reset
// and clear lower every dot at once.
`default_nettype none

module braille_cell_drive_sequencer #(
    parameter int COLUMN_COUNT = bcds_pkg::DEF_COLUMN_COUNT,
    parameter int ROW_COUNT    = bcds_pkg::DEF_ROW_COUNT
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    bcds_in_if.sink                            i_cmd,
    bcds_out_if.source                         o_res,
    input  wire                                i_cfg_we,
    input  wire [bcds_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [bcds_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PAIRS       = (COLUMN_COUNT + 1) / 2;
    localparam int FRAME_PAIRS = (PAIRS > bcds_pkg::MAX_FRAME_PAIRS) ?
                                 bcds_pkg::MAX_FRAME_PAIRS : PAIRS;

    logic               w_in_ready;
    bcds_pkg::t_dp_cmd  w_cmd;
    bcds_pkg::t_dp_stat w_stat;

    assign i_cmd.ready = w_in_ready;

    bcds_ctrl #(
        .FRAME_PAIRS (FRAME_PAIRS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bcds_datapath #(
        .COLUMN_COUNT (COLUMN_COUNT),
        .ROW_COUNT    (ROW_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capture  (i_cmd.valid && w_in_ready),
        .i_in_cmd   (i_cmd.cmd),
        .i_in_row   (i_cmd.dot_row),
        .i_in_col   (i_cmd.dot_col),
        .i_in_on    (i_cmd.dot_on),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire
